// File: design/ckbs_pkg.sv
`default_nettype none
package ckbs_pkg;

  // request and result items
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] key;
    logic [1:0]  size_code;
    logic [63:0] value;
    logic [7:0]  read_addr;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] position;
    logic [3:0] size_bytes;
    logic [7:0] read_byte;
  } rsp_t;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOBYTES = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOKEY   = 2'd3;

  localparam logic [1:0] SZ_ONE   = 2'd0;
  localparam logic [1:0] SZ_FOUR  = 2'd1;
  localparam logic [1:0] SZ_EIGHT = 2'd2;
  // spare code, decodes as eight bytes
  localparam logic [1:0] SZ_SPARE = 2'd3;

  // widest byte address and entry index over the legal parameter range
  localparam int MAX_AW = 13;
  localparam int MAX_IW = 11;

  // broadcast to every byte cell
  typedef struct packed {
    logic              wr;
    logic [MAX_AW-1:0] base;
    logic [3:0]        nbytes;
    logic [63:0]       data;
    logic              shift;
    logic [MAX_AW-1:0] shpos;
  } byte_ctrl_t;

  // broadcast to every entry cell
  typedef struct packed {
    logic              ld;
    logic [MAX_IW-1:0] ld_idx;
    logic [15:0]       key;
    logic [MAX_AW-1:0] pos;
    logic [3:0]        size;
    logic              rm;
    logic [MAX_IW-1:0] rm_idx;
    logic [3:0]        rm_sz;
  } entry_ctrl_t;

endpackage
`default_nettype wire

// File: design/ckbs_byte_cell.sv
`default_nettype none
module ckbs_byte_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ckbs_pkg::byte_ctrl_t  ctrl,
  input  wire logic [7:0]            up,
  output logic [7:0]                 q
);
  import ckbs_pkg::*;

  localparam logic [MAX_AW:0] IDX = (MAX_AW+1)'(INDEX);

  logic [MAX_AW:0] lo;
  logic [MAX_AW:0] hi;
  logic [MAX_AW:0] off;
  logic            hit;
  logic            above;
  logic [63:0]     sh;

  // write window of an allocation and compaction region
  always_comb begin
    lo    = {1'b0, ctrl.base};
    hi    = lo + (MAX_AW+1)'(ctrl.nbytes);
    off   = IDX - lo;
    hit   = (IDX >= lo) && (IDX < hi);
    above = IDX >= {1'b0, ctrl.shpos};
    sh    = ctrl.data >> {off[2:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.shift && above) begin
      q <= up;
    end else if (ctrl.wr && hit) begin
      q <= sh[7:0];
    end
  end

endmodule
`default_nettype wire

// File: design/ckbs_entry_cell.sv
`default_nettype none
module ckbs_entry_cell #(
  parameter int INDEX = 0,
  parameter int AW    = 8
) (
  input  wire logic                  clk,
  input  wire ckbs_pkg::entry_ctrl_t ctrl,
  input  wire logic [15:0]           up_key,
  input  wire logic [AW-1:0]         up_pos,
  input  wire logic [3:0]            up_size,
  output logic [15:0]                key,
  output logic [AW-1:0]              pos,
  output logic [3:0]                 size
);
  import ckbs_pkg::*;

  localparam logic [MAX_IW-1:0] IDX = MAX_IW'(INDEX);

  logic [AW-1:0] up_adj;

  // neighbor's position less the freed size, floored at zero
  always_comb begin
    up_adj = (up_pos > AW'(ctrl.rm_sz)) ? up_pos - AW'(ctrl.rm_sz) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.rm && IDX >= ctrl.rm_idx) begin
      key  <= up_key;
      pos  <= up_adj;
      size <= up_size;
    end else if (ctrl.ld && IDX == ctrl.ld_idx) begin
      key  <= ctrl.key;
      pos  <= ctrl.pos[AW-1:0];
      size <= ctrl.size;
    end
  end

endmodule
`default_nettype wire

// File: design/compacting_keyed_byte_store_core.sv
`default_nettype none
// channel | dir | handshake           | payload
// in      | in  | in_valid / in_stall  | in_req  (req_t)
// out     | out | out_valid / out_stall| out_rsp (rsp_t)
//
// Allocate and read go from idle straight to the done state. A free scans the
// entry row one entry a cycle (up to MAX_ENTRIES) and then shifts the byte row
// down one byte a cycle for the freed size (1 to 8).
// Reset clears the byte row, the fill mark and the entry count.
// in_stall is high while a request is at work; a finished result waits
// in its register while out_stall is high.
module compacting_keyed_byte_store_core #(
  parameter int STORE_BYTES = 256,
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ckbs_pkg::req_t  in_req,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ckbs_pkg::rsp_t       out_rsp
);
  import ckbs_pkg::*;

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int UW   = $clog2(STORE_BYTES + 1);
  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int RD_N = (STORE_BYTES < 256) ? STORE_BYTES : 256;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic [UW-1:0] used;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [3:0]    left;
  logic [AW-1:0] fpos;
  logic [15:0]   fkey;
  rsp_t          res;

  logic [7:0]    bq   [STORE_BYTES];
  logic [15:0]   ekey [MAX_ENTRIES];
  logic [AW-1:0] epos [MAX_ENTRIES];
  logic [3:0]    esz  [MAX_ENTRIES];

  byte_ctrl_t  bctl;
  entry_ctrl_t ectl;

  logic          acc;
  logic [3:0]    asz;
  logic [UW:0]   room;
  logic [7:0]    rbyte;
  logic [15:0]   skey;
  logic [AW-1:0] spos;
  logic [3:0]    ssz;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // byte row
  for (genvar a = 0; a < STORE_BYTES; a++) begin : g_byte
    logic [7:0] up;
    if (a + 1 < STORE_BYTES) begin : g_mid
      assign up = bq[a+1];
    end else begin : g_top
      assign up = '0;
    end
    ckbs_byte_cell #(.INDEX(a)) u_cell (
      .clk(clk), .rst(rst), .ctrl(bctl), .up(up), .q(bq[a])
    );
  end

  // entry row
  for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_ent
    logic [15:0]   uk;
    logic [AW-1:0] up;
    logic [3:0]    us;
    if (e + 1 < MAX_ENTRIES) begin : g_mid
      assign uk = ekey[e+1];
      assign up = epos[e+1];
      assign us = esz[e+1];
    end else begin : g_top
      assign uk = '0;
      assign up = '0;
      assign us = '0;
    end
    ckbs_entry_cell #(.INDEX(e), .AW(AW)) u_cell (
      .clk(clk), .ctrl(ectl), .up_key(uk), .up_pos(up), .up_size(us),
      .key(ekey[e]), .pos(epos[e]), .size(esz[e])
    );
  end

  // allocation size, free room, read select and scanned entry select
  always_comb begin
    unique case (in_req.size_code)
      SZ_ONE:  asz = 4'd1;
      SZ_FOUR: asz = 4'd4;
      default: asz = 4'd8;
    endcase
    room  = (UW+1)'(STORE_BYTES) - {1'b0, used};
    rbyte = '0;
    for (int a = 0; a < RD_N; a++) begin
      if (in_req.read_addr == 8'(a)) rbyte = bq[a];
    end
    skey = '0;
    spos = '0;
    ssz  = '0;
    for (int e = 0; e < MAX_ENTRIES; e++) begin
      if (idx[IW-1:0] == IW'(e)) begin
        skey = ekey[e];
        spos = epos[e];
        ssz  = esz[e];
      end
    end
  end

  // cell controls
  always_comb begin
    bctl        = '0;
    ectl        = '0;
    bctl.base   = MAX_AW'(used);
    bctl.nbytes = asz;
    bctl.data   = in_req.value;
    bctl.shpos  = MAX_AW'(fpos);
    ectl.ld_idx = MAX_IW'(count);
    ectl.key    = in_req.key;
    ectl.pos    = MAX_AW'(used);
    ectl.size   = asz;
    ectl.rm_idx = MAX_IW'(idx);
    ectl.rm_sz  = ssz;
    if (acc && in_req.opcode == OP_ALLOC && room >= (UW+1)'(asz)
        && count < CW'(MAX_ENTRIES)) begin
      bctl.wr = 1'b1;
      ectl.ld = 1'b1;
    end
    if (state == S_SCAN && idx < count && skey == fkey) ectl.rm = 1'b1;
    if (state == S_SHIFT && left != 4'd0) bctl.shift = 1'b1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: load when done, clear once taken
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            fkey <= in_req.key;
            idx  <= '0;
            priority if (in_req.opcode == OP_ALLOC) begin
              state <= S_DONE;
              priority if (room < (UW+1)'(asz)) begin
                res <= '{ST_NOBYTES, 8'd0, 4'd0, 8'd0};
              end else if (count >= CW'(MAX_ENTRIES)) begin
                res <= '{ST_FULL, 8'd0, 4'd0, 8'd0};
              end else begin
                res   <= '{ST_OK, 8'(used), asz, 8'd0};
                used  <= used + UW'(asz);
                count <= count + CW'(1);
              end
            end else if (in_req.opcode == OP_FREE) begin
              res   <= '0;
              state <= S_SCAN;
            end else if (in_req.opcode == OP_READ) begin
              res   <= '{ST_OK, 8'd0, 4'd0, rbyte};
              state <= S_DONE;
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          priority if (idx >= count) begin
            res   <= '{ST_NOKEY, 8'd0, 4'd0, 8'd0};
            state <= S_DONE;
          end else if (skey == fkey) begin
            fpos  <= spos;
            left  <= ssz;
            res   <= '{ST_OK, 8'(spos), ssz, 8'd0};
            count <= count - CW'(1);
            used  <= used - UW'(ssz);
            state <= S_SHIFT;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SHIFT: begin
          if (left != 4'd0) left <= left - 4'd1;
          else state <= S_DONE;
        end
        default: begin
          if (!out_valid || !out_stall) begin
            out_rsp <= res;
            state   <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: verif/ckbs_checker.sv
`default_nettype none
module ckbs_checker #(
  parameter int STORE_BYTES = 256,
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_stall,
  input  wire ckbs_pkg::req_t  in_req,
  input  wire logic            out_valid,
  input  wire logic            out_stall,
  input  wire ckbs_pkg::rsp_t  out_rsp,
  output int                   fail_count,
  output int                   pending_rsps,
  output int                   rsp_count
);
  import ckbs_pkg::*;

  // shadow state of the store
  logic [7:0]  shadow_bytes [STORE_BYTES];
  logic [15:0] tag_row [MAX_ENTRIES];
  int          pos_row [MAX_ENTRIES];
  int          size_row [MAX_ENTRIES];
  int          fill_mark;
  int          live_entries;
  rsp_t        expected_rsps [$];

  assign pending_rsps = expected_rsps.size();

  function automatic rsp_t predict_store(input req_t r);
    rsp_t res;
    int sz, i, hit, p;
    res = '0;
    case (r.opcode)
      OP_ALLOC: begin
        sz = (r.size_code == SZ_ONE) ? 1 : (r.size_code == SZ_FOUR) ? 4 : 8;
        if (fill_mark > STORE_BYTES || STORE_BYTES - fill_mark < sz) begin
          res.status = ST_NOBYTES;
        end else if (live_entries >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          for (i = 0; i < sz; i++) shadow_bytes[fill_mark + i] = r.value[8*i +: 8];
          tag_row[live_entries] = r.key;
          pos_row[live_entries] = fill_mark;
          size_row[live_entries] = sz;
          live_entries++;
          res.status = ST_OK;
          res.position = fill_mark[7:0];
          res.size_bytes = sz[3:0];
          fill_mark += sz;
        end
      end
      OP_FREE: begin
        hit = -1;
        for (i = 0; i < live_entries; i++)
          if (hit < 0 && tag_row[i] == r.key) hit = i;
        if (hit < 0) begin
          res.status = ST_NOKEY;
        end else begin
          p = pos_row[hit];
          sz = size_row[hit];
          for (i = hit; i + 1 < live_entries; i++) begin
            tag_row[i] = tag_row[i+1];
            pos_row[i] = (pos_row[i+1] > sz) ? pos_row[i+1] - sz : 0;
            size_row[i] = size_row[i+1];
          end
          live_entries--;
          for (i = p; i < STORE_BYTES; i++)
            shadow_bytes[i] = (i + sz < STORE_BYTES) ? shadow_bytes[i+sz] : 8'h00;
          fill_mark = (fill_mark >= sz) ? fill_mark - sz : 0;
          res.status = ST_OK;
          res.position = p[7:0];
          res.size_bytes = sz[3:0];
        end
      end
      OP_READ: begin
        if (int'(r.read_addr) < STORE_BYTES) res.read_byte = shadow_bytes[r.read_addr];
      end
      default: ;
    endcase
    return res;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) shadow_bytes[i] = 8'h00;
      fill_mark = 0;
      live_entries = 0;
      expected_rsps.delete();
      fail_count = 0;
      rsp_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_rsp);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_rsp.status !== exp_rsp.status || out_rsp.position !== exp_rsp.position ||
              out_rsp.size_bytes !== exp_rsp.size_bytes ||
              out_rsp.read_byte !== exp_rsp.read_byte) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p got %p", exp_rsp, out_rsp);
          end
        end
      end
      if (in_valid && !in_stall) expected_rsps.push_back(predict_store(in_req));
    end
  end
endmodule
`default_nettype wire

// File: verif/tb_compacting_keyed_byte_store_core.sv
`default_nettype none
module tb_compacting_keyed_byte_store_core;
  import ckbs_pkg::*;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  req_t in_req;
  rsp_t out_rsp;
  int   fail_count, pending_rsps, rsp_count;
  int   idle_cycles;
  bit   long_hold;
  logic [15:0] used_keys [$];

  compacting_keyed_byte_store_core dut (.*);

  ckbs_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_req, .out_valid, .out_stall, .out_rsp,
    .fail_count, .pending_rsps, .rsp_count
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input req_t r);
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic req_t make_req(input logic [1:0] op, input logic [15:0] k,
                                    input logic [1:0] sc, input logic [63:0] v,
                                    input logic [7:0] a);
    req_t r;
    r.opcode = op; r.key = k; r.size_code = sc; r.value = v; r.read_addr = a;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly keys allocated before, some random keys
  function automatic logic [15:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 4) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return 16'($urandom());
  endfunction

  initial begin
    req_t r;
    int burst, n, mode;
    in_valid = 1'b0;
    in_req = '0;
    long_hold = 0;
    idle_cycles = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every size and opcode, extremes, duplicates, misses
    send_request(make_req(OP_READ, 16'h0, SZ_ONE, '0, 8'h00));
    send_request(make_req(OP_FREE, 16'hFFFF, SZ_ONE, '0, 8'h00));
    send_request(make_req(OP_ALLOC, 16'h0000, SZ_ONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
    send_request(make_req(OP_ALLOC, 16'hFFFF, SZ_FOUR, 64'h0123_4567_89AB_CDEF, 8'h00));
    send_request(make_req(OP_ALLOC, 16'h1234, SZ_EIGHT, 64'hFEDC_BA98_7654_3210, 8'h00));
    send_request(make_req(OP_ALLOC, 16'h1234, SZ_SPARE, 64'hAAAA_5555_AAAA_5555, 8'h00));
    send_request(make_req(OP_NOP, 16'hFFFF, SZ_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
    for (int i = 0; i < 14; i++)
      send_request(make_req(OP_READ, '0, '0, '0, i[7:0]));
    send_request(make_req(OP_FREE, 16'hFFFF, SZ_ONE, '0, 8'h00));
    send_request(make_req(OP_FREE, 16'h1234, SZ_ONE, '0, 8'h00));
    send_request(make_req(OP_READ, '0, '0, '0, 8'hFF));
    send_request(make_req(OP_FREE, 16'h1234, SZ_ONE, '0, 8'h00));
    send_request(make_req(OP_FREE, 16'h0000, SZ_ONE, '0, 8'h00));

    // fill the table with one-byte entries past its limit, then fill the bytes
    for (int i = 0; i < 66; i++) begin
      send_request(make_req(OP_ALLOC, i[15:0], SZ_ONE, rand64(), '0));
      used_keys.push_back(i[15:0]);
    end
    for (int i = 0; i < 40; i++)
      send_request(make_req(OP_FREE, pick_key(), '0, '0, '0));
    // long receiver hold-off while requests keep coming
    long_hold = 1;
    for (int i = 0; i < 40; i++)
      send_request(make_req(OP_ALLOC, 16'($urandom()), SZ_EIGHT, rand64(), '0));
    // sender waits for every result
    in_valid <= 1'b0;
    while (pending_rsps != 0) @(posedge clk);

    // random: bursts and gaps, mostly allocate/free with reads mixed in
    n = 0;
    while (n < 1500) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        mode = $urandom_range(0, 99);
        if (mode < 40)
          r = make_req(OP_ALLOC, pick_key(), 2'($urandom()), rand64(), 8'($urandom()));
        else if (mode < 70)
          r = make_req(OP_FREE, pick_key(), 2'($urandom()), rand64(), 8'($urandom()));
        else if (mode < 95)
          r = make_req(OP_READ, 16'($urandom()), 2'($urandom()), rand64(),
                       8'($urandom()));
        else
          r = make_req(OP_NOP, 16'($urandom()), 2'($urandom()), rand64(),
                       8'($urandom()));
        if (r.opcode == OP_ALLOC && used_keys.size() < 200) used_keys.push_back(r.key);
        if ($urandom_range(0, 20) == 0) r.read_addr = 8'hFF;
        send_request(r);
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // drain and allow for trailing work
    while (pending_rsps != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered allocate of all widths, table and byte exhaustion, frees with");
    $display("compaction, duplicate and missing keys, reads; %0d results", rsp_count);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
design/ckbs_pkg.sv
design/ckbs_byte_cell.sv
design/ckbs_entry_cell.sv
design/compacting_keyed_byte_store_core.sv
verif/ckbs_checker.sv
verif/tb_compacting_keyed_byte_store_core.sv
